// ----- design/seplu_pkg.sv -----
// shared types, constants and helpers for the sparse entry position lookup unit
`default_nettype none

package seplu_pkg;

  localparam int PTR_W     = 15;
  localparam int IDX_W     = 11;
  localparam int POS_W     = 15;
  localparam int SLOT_W    = 14;
  localparam int COORD_W   = 10;
  localparam int DIM_W     = 11;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 15;

  localparam int DEF_MAX_LINES    = 1024;
  localparam int DEF_MAX_NONZEROS = 16384;

  localparam logic [OP_W-1:0] OP_WR_PTR = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_IDX = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NNZ    = 3'd4;

  typedef struct packed {
    logic             storage_format;
    logic             index_base;
    logic [DIM_W-1:0] row_count;
    logic [DIM_W-1:0] col_count;
    logic [POS_W-1:0] nonzero_count;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
    logic             out_of_bounds;
  } res_t;

  // stored pointer to zero-based slot, clamped to the index store depth
  function automatic logic [POS_W-1:0] slot_of(input logic [PTR_W-1:0] ptr,
                                               input logic base,
                                               input int unsigned max_nz);
    logic [POS_W-1:0] s;
    s = (ptr >= PTR_W'(base)) ? POS_W'(ptr - PTR_W'(base)) : '0;
    if (32'(s) > max_nz) begin
      s = POS_W'(max_nz);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- design/seplu_if.sv -----
// handshake channel interfaces for the lookup unit
`default_nettype none

interface seplu_in_if;
  logic                                valid;
  logic                                ready;
  logic [seplu_pkg::OP_W-1:0]          operation;
  logic [seplu_pkg::SLOT_W-1:0]        store_slot;
  logic [seplu_pkg::PTR_W-1:0]         store_value;
  logic [seplu_pkg::COORD_W-1:0]       row_index;
  logic [seplu_pkg::COORD_W-1:0]       col_index;

  modport source (output valid, operation, store_slot, store_value, row_index, col_index,
                  input ready);
  modport sink (input valid, operation, store_slot, store_value, row_index, col_index,
                output ready);
endinterface

interface seplu_out_if;
  logic                          valid;
  logic                          ready;
  logic [seplu_pkg::POS_W-1:0]   position;
  logic                          found;
  logic                          out_of_bounds;

  modport source (output valid, position, found, out_of_bounds, input ready);
  modport sink (input valid, position, found, out_of_bounds, output ready);
endinterface

interface seplu_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [seplu_pkg::CFG_IDX_W-1:0]   index;
  logic [seplu_pkg::CFG_DAT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/sparse_entry_position_lookup_unit.sv -----
// top level of the sparse entry position lookup unit
// holds the pointer and index stores of a compressed row or column pattern and
// answers (row, column) lookups with the zero-based slot of the entry.
// channels: in_ch takes write-pointer, write-index and lookup items, out_ch
// returns one result per lookup, cfg_ch writes format, base, sizes and the
// nonzero count (always ready, write only while no lookup is in flight).
// a write item gives no result, so writes can go back to back. a lookup
// fetches the two line pointers in states P0, P1 and P2, then streams the
// index ram one slot a cycle up to the match or end of line; an empty line
// skips the scan and an out of range lookup skips the pointer fetch. the
// next item is taken in the cycle after the result moves to the output
// register; the index ram has a single read port and the unit handles one
// lookup at a time.
// reset clears control and configuration (rows 1, columns 1, nonzeros 0);
// the stores hold nothing defined until written and are not cleared.
// when out_ch stalls the result waits in the output register; the sequencer
// can finish the next lookup and holds it until the register frees up.
`default_nettype none

module sparse_entry_position_lookup_unit #(
  parameter int MAX_LINES    = seplu_pkg::DEF_MAX_LINES,
  parameter int MAX_NONZEROS = seplu_pkg::DEF_MAX_NONZEROS
) (
  input wire logic       clk,
  input wire logic       rst_n,
  seplu_in_if.sink       in_ch,
  seplu_out_if.source    out_ch,
  seplu_cfg_if.sink      cfg_ch
);

  localparam int LP_DEPTH = MAX_LINES + 1;
  localparam int LP_AW    = (LP_DEPTH > 1) ? $clog2(LP_DEPTH) : 1;
  localparam int NZ_AW    = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;

  seplu_pkg::cfg_t              cfg_r;
  logic                         out_valid_r;
  seplu_pkg::res_t              out_res_r;

  logic                         in_xfer;
  logic                         lookup_start;
  logic [31:0]                  slot_ext;
  logic                         lp_we;
  logic                         nz_we;
  logic [LP_AW-1:0]             lp_raddr;
  logic [seplu_pkg::PTR_W-1:0]  lp_rdata;
  logic [NZ_AW-1:0]             nz_raddr;
  logic [seplu_pkg::IDX_W-1:0]  nz_rdata;
  logic                         scan_idle;
  logic                         scan_res_valid;
  seplu_pkg::res_t              scan_res;
  logic                         res_take;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.storage_format <= 1'b0;
      cfg_r.index_base     <= 1'b0;
      cfg_r.row_count      <= seplu_pkg::DIM_W'(1);
      cfg_r.col_count      <= seplu_pkg::DIM_W'(1);
      cfg_r.nonzero_count  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        seplu_pkg::REG_FORMAT: cfg_r.storage_format <= cfg_ch.data[0];
        seplu_pkg::REG_BASE:   cfg_r.index_base     <= cfg_ch.data[0];
        seplu_pkg::REG_ROWS:   cfg_r.row_count      <= cfg_ch.data[seplu_pkg::DIM_W-1:0];
        seplu_pkg::REG_COLS:   cfg_r.col_count      <= cfg_ch.data[seplu_pkg::DIM_W-1:0];
        seplu_pkg::REG_NNZ:    cfg_r.nonzero_count  <= cfg_ch.data[seplu_pkg::POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input decode and store writes
  assign in_ch.ready  = scan_idle;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign lookup_start = in_xfer && (in_ch.operation == seplu_pkg::OP_LOOKUP);
  assign slot_ext     = 32'(in_ch.store_slot);
  assign lp_we = in_xfer && (in_ch.operation == seplu_pkg::OP_WR_PTR) &&
                 (slot_ext < 32'(LP_DEPTH));
  assign nz_we = in_xfer && (in_ch.operation == seplu_pkg::OP_WR_IDX) &&
                 (slot_ext < 32'(MAX_NONZEROS));

  seplu_ram #(
    .WIDTH (seplu_pkg::PTR_W),
    .DEPTH (LP_DEPTH)
  ) u_lp_ram (
    .clk   (clk),
    .we    (lp_we),
    .waddr (slot_ext[LP_AW-1:0]),
    .wdata (in_ch.store_value),
    .raddr (lp_raddr),
    .rdata (lp_rdata)
  );

  seplu_ram #(
    .WIDTH (seplu_pkg::IDX_W),
    .DEPTH (MAX_NONZEROS)
  ) u_nz_ram (
    .clk   (clk),
    .we    (nz_we),
    .waddr (slot_ext[NZ_AW-1:0]),
    .wdata (in_ch.store_value[seplu_pkg::IDX_W-1:0]),
    .raddr (nz_raddr),
    .rdata (nz_rdata)
  );

  seplu_scan #(
    .MAX_LINES    (MAX_LINES),
    .MAX_NONZEROS (MAX_NONZEROS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (lookup_start),
    .row_index (in_ch.row_index),
    .col_index (in_ch.col_index),
    .lp_raddr  (lp_raddr),
    .lp_rdata  (lp_rdata),
    .nz_raddr  (nz_raddr),
    .nz_rdata  (nz_rdata),
    .idle      (scan_idle),
    .res_valid (scan_res_valid),
    .res       (scan_res),
    .res_take  (res_take)
  );

  // output register
  assign res_take = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= scan_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && scan_res_valid) begin
      out_res_r <= scan_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.position      = out_res_r.position;
  assign out_ch.found         = out_res_r.found;
  assign out_ch.out_of_bounds = out_res_r.out_of_bounds;

  // checks
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    lookup_start |=> !scan_idle)
    else $error("lookup accepted but sequencer stayed idle");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (lp_we || nz_we) |-> scan_idle)
    else $error("store written during a lookup");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_res_valid && !res_take) |=> (scan_res_valid && $stable(scan_res)))
    else $error("pending result dropped or changed");

  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.found) |-> !out_res_r.out_of_bounds)
    else $error("out of range lookup reported as found");

endmodule

`default_nettype wire

// ----- design/seplu_ram.sv -----
// generic single-write single-read ram with registered read data
`default_nettype none

module seplu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- design/seplu_scan.sv -----
// lookup sequencer: pointer fetch and pipelined scan of the index store
`default_nettype none

module seplu_scan #(
  parameter int MAX_LINES    = seplu_pkg::DEF_MAX_LINES,
  parameter int MAX_NONZEROS = seplu_pkg::DEF_MAX_NONZEROS,
  localparam int LP_AW = (MAX_LINES + 1 > 1) ? $clog2(MAX_LINES + 1) : 1,
  localparam int NZ_AW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire seplu_pkg::cfg_t                  cfg,
  input  wire logic                             start,
  input  wire logic [seplu_pkg::COORD_W-1:0]    row_index,
  input  wire logic [seplu_pkg::COORD_W-1:0]    col_index,
  output logic      [LP_AW-1:0]                 lp_raddr,
  input  wire logic [seplu_pkg::PTR_W-1:0]      lp_rdata,
  output logic      [NZ_AW-1:0]                 nz_raddr,
  input  wire logic [seplu_pkg::IDX_W-1:0]      nz_rdata,
  output logic                                  idle,
  output logic                                  res_valid,
  output seplu_pkg::res_t                       res,
  input  wire logic                             res_take
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_P0   = 6'b000010,
    S_P1   = 6'b000100,
    S_P2   = 6'b001000,
    S_SCAN = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [seplu_pkg::COORD_W-1:0]   line_r, line_nxt;
  logic [seplu_pkg::IDX_W-1:0]     target_r, target_nxt;
  logic [seplu_pkg::POS_W-1:0]     start_r, start_nxt;
  logic [seplu_pkg::POS_W-1:0]     end_r, end_nxt;
  logic [seplu_pkg::POS_W-1:0]     k_r, k_nxt;
  logic [seplu_pkg::POS_W-1:0]     pk_r, pk_nxt;
  logic                            pend_r, pend_nxt;
  seplu_pkg::res_t                 res_r, res_nxt;

  logic                            oob;
  logic [seplu_pkg::COORD_W-1:0]   line_sel;
  logic [seplu_pkg::COORD_W-1:0]   minor_sel;
  logic [31:0]                     lp_addr_ext;
  logic [31:0]                     nz_addr_ext;
  logic                            hit;
  logic [seplu_pkg::POS_W-1:0]     slot_now;

  assign oob = ({1'b0, row_index} >= cfg.row_count) || ({1'b0, col_index} >= cfg.col_count);
  assign line_sel  = cfg.storage_format ? col_index : row_index;
  assign minor_sel = cfg.storage_format ? row_index : col_index;

  assign lp_addr_ext = (state_r == S_P1) ? (32'(line_r) + 32'd1) : 32'(line_r);
  assign lp_raddr    = lp_addr_ext[LP_AW-1:0];
  assign nz_addr_ext = 32'(k_r);
  assign nz_raddr    = nz_addr_ext[NZ_AW-1:0];

  assign slot_now = seplu_pkg::slot_of(lp_rdata, cfg.index_base, MAX_NONZEROS);
  assign hit      = pend_r && (nz_rdata == target_r);

  always_comb begin
    state_nxt  = state_r;
    line_nxt   = line_r;
    target_nxt = target_r;
    start_nxt  = start_r;
    end_nxt    = end_r;
    k_nxt      = k_r;
    pk_nxt     = pk_r;
    pend_nxt   = pend_r;
    res_nxt    = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          res_nxt.position      = cfg.nonzero_count;
          res_nxt.found         = 1'b0;
          res_nxt.out_of_bounds = oob;
          line_nxt   = line_sel;
          target_nxt = seplu_pkg::IDX_W'(minor_sel) + seplu_pkg::IDX_W'(cfg.index_base);
          if (oob || (32'(line_sel) + 32'd1 > 32'(MAX_LINES))) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_P0;
          end
        end
      end
      S_P0: begin
        state_nxt = S_P1;
      end
      S_P1: begin
        start_nxt = slot_now;
        state_nxt = S_P2;
      end
      S_P2: begin
        end_nxt  = slot_now;
        k_nxt    = start_r;
        pend_nxt = 1'b0;
        if (start_r < slot_now) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_nxt.position = pk_r;
          res_nxt.found    = 1'b1;
          state_nxt        = S_DONE;
        end else if (k_r >= end_r) begin
          state_nxt = S_DONE;
        end else begin
          pk_nxt   = k_r;
          pend_nxt = 1'b1;
          k_nxt    = k_r + 1'b1;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    line_r   <= line_nxt;
    target_r <= target_nxt;
    start_r  <= start_nxt;
    end_r    <= end_nxt;
    k_r      <= k_nxt;
    pk_r     <= pk_nxt;
    res_r    <= res_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

`default_nettype wire
